/* sv/acvs_pkg.sv */
package acvs_pkg;

  // field and datapath widths
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned CHAN_W     = 12;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned FACE_W     = CHAN_W * NUM_CHAN;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_FACES  = 2 * NUM_AXES;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned WGT_W      = MAG_W + GAIN_W;
  localparam int unsigned PROD_W     = WGT_W + CHAN_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned FRAC_SHIFT = 30;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CNT_IN_W   = 5;

  // max path: 8.4 color rounded to an integer
  localparam int unsigned MAX_FRAC   = 4;

  // configuration port
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned IDX_LSB    = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

  // register indexes
  localparam logic [IDX_W-1:0] REG_X_NEG = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_POS = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_NEG = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_POS = 3'd3;
  localparam logic [IDX_W-1:0] REG_Z_NEG = 3'd4;
  localparam logic [IDX_W-1:0] REG_Z_POS = 3'd5;
  localparam logic [IDX_W-1:0] REG_GAIN  = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  // element 0 is red, 1 green, 2 blue
  typedef chan_t [NUM_CHAN-1:0] rgb_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [NUM_CHAN-1:0] pix_rgb_t;

endpackage

/* sv/ambient_cube_vertex_shade_unit.sv */
// Ambient-cube vertex shader. Each request carries a Q1.14 normal and a vertex
// count; every axis picks the negative or positive face of the cube by the sign
// of its component, weights it by |component| times the u4.12 gain, and the
// three weighted 8.4 colors are summed, rounded and clamped to 255 per channel.
// An all-zero normal takes the per-channel maximum of all six faces instead.
// The color goes out once per vertex (count saturated to MAX_REPEAT, zero
// counts give nothing) with last_vertex_o on the final one; alpha is an
// implied 255. Requests are taken one per cycle, while in_stall_o is low, into
// a four-stage pipeline (select, weight, multiply, sum/round) followed by an
// output register. A request with count N holds the output register until its
// N vertices are taken, while later requests back up in the stages. Faces and
// gain are written over the APB port at byte address 8*index; the user must
// write them only while idle, which the block itself does not enforce.
module ambient_cube_vertex_shade_unit
  import acvs_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [NORM_W-1:0]  normal_x_i,
  input  logic signed [NORM_W-1:0]  normal_y_i,
  input  logic signed [NORM_W-1:0]  normal_z_i,
  input  logic [CNT_IN_W-1:0]       vertex_count_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [PIX_W-1:0]          red_o,
  output logic [PIX_W-1:0]          green_o,
  output logic [PIX_W-1:0]          blue_o,
  output logic                      last_vertex_o,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  localparam int unsigned CW = $clog2(MAX_REPEAT + 1);

  // configuration registers
  logic [FACE_W-1:0] face_q [NUM_FACES];
  logic [GAIN_W-1:0] gain_q;
  logic [IDX_W-1:0]  cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[IDX_LSB +: IDX_W];
  assign cfg_wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        face_q[f] <= '0;
      end
      gain_q <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        REG_X_NEG, REG_X_POS, REG_Y_NEG, REG_Y_POS, REG_Z_NEG, REG_Z_POS: begin
          face_q[cfg_idx] <= pwdata[FACE_W-1:0];
        end
        REG_GAIN: begin
          gain_q <= pwdata[GAIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx) inside
      REG_X_NEG, REG_X_POS, REG_Y_NEG, REG_Y_POS, REG_Z_NEG, REG_Z_POS: begin
        prdata = DATA_W'(face_q[cfg_idx]);
      end
      REG_GAIN: begin
        prdata = DATA_W'(gain_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // pipeline flow control
  logic          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic          s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  logic          out_take, out_free;
  logic [CW-1:0] out_rem_q;

  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || (out_take && (out_rem_q == CW'(1)));
  assign s4_rdy     = !s4_valid_q || out_free;
  assign s3_rdy     = !s3_valid_q || s4_rdy;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  // stage 1: sign, magnitude, face select, pairwise face maxima
  logic signed [NORM_W-1:0] norm [NUM_AXES];
  logic [MAG_W-1:0]         s1_mag_d [NUM_AXES];
  rgb_t                     s1_face_d [NUM_AXES];
  rgb_t                     s1_pmax_d [NUM_AXES];
  logic [CW-1:0]            in_cnt;
  logic                     in_zero;

  assign norm[0] = normal_x_i;
  assign norm[1] = normal_y_i;
  assign norm[2] = normal_z_i;
  assign in_zero = (normal_x_i == '0) && (normal_y_i == '0) && (normal_z_i == '0);

  // count saturated to the repeat limit
  assign in_cnt = (int'(vertex_count_i) > int'(MAX_REPEAT)) ? CW'(MAX_REPEAT)
                                                            : CW'(vertex_count_i);

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rgb_t face_lo, face_hi;
    assign face_lo = rgb_t'(face_q[2*a]);
    assign face_hi = rgb_t'(face_q[2*a+1]);
    // negative picks the first face of the pair, zero or positive the second
    assign s1_mag_d[a]  = norm[a][NORM_W-1] ? (MAG_W'(0) - {norm[a][NORM_W-1], norm[a]})
                                             : {1'b0, norm[a]};
    assign s1_face_d[a] = norm[a][NORM_W-1] ? face_lo : face_hi;
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_pmax
      assign s1_pmax_d[a][c] = (face_lo[c] > face_hi[c]) ? face_lo[c] : face_hi[c];
    end
  end

  logic [MAG_W-1:0] s1_mag_q [NUM_AXES];
  rgb_t             s1_face_q [NUM_AXES];
  rgb_t             s1_pmax_q [NUM_AXES];
  logic             s1_zero_q;
  logic [CW-1:0]    s1_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_q <= in_valid_i && (vertex_count_i != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_mag_q  <= s1_mag_d;
      s1_face_q <= s1_face_d;
      s1_pmax_q <= s1_pmax_d;
      s1_zero_q <= in_zero;
      s1_cnt_q  <= in_cnt;
    end
  end

  // stage 2: axis weight and six-face maximum
  logic [WGT_W-1:0] s2_wgt_q [NUM_AXES];
  rgb_t             s2_face_q [NUM_AXES];
  rgb_t             s2_max_q;
  logic             s2_zero_q;
  logic [CW-1:0]    s2_cnt_q;
  rgb_t             s2_max_d;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      s2_max_d[c] = s1_pmax_q[0][c];
      if (s1_pmax_q[1][c] > s2_max_d[c]) s2_max_d[c] = s1_pmax_q[1][c];
      if (s1_pmax_q[2][c] > s2_max_d[c]) s2_max_d[c] = s1_pmax_q[2][c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s2_wgt_q[a] <= WGT_W'(s1_mag_q[a]) * WGT_W'(gain_q);
      end
      s2_face_q <= s1_face_q;
      s2_max_q  <= s2_max_d;
      s2_zero_q <= s1_zero_q;
      s2_cnt_q  <= s1_cnt_q;
    end
  end

  // stage 3: color times weight, one product per axis and channel
  logic [PROD_W-1:0] s3_prod_q [NUM_AXES][NUM_CHAN];
  rgb_t              s3_max_q;
  logic              s3_zero_q;
  logic [CW-1:0]     s3_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          s3_prod_q[a][c] <= PROD_W'(s2_face_q[a][c]) * PROD_W'(s2_wgt_q[a]);
        end
      end
      s3_max_q  <= s2_max_q;
      s3_zero_q <= s2_zero_q;
      s3_cnt_q  <= s2_cnt_q;
    end
  end

  // stage 4: sum, round half up, clamp; zero normal takes the face maximum
  pix_rgb_t s4_pix_d;

  always_comb begin
    logic [SUM_W-1:0]              sum;
    logic [SUM_W-FRAC_SHIFT-1:0]   sum_int;
    logic [CHAN_W:0]               max_rnd;
    logic [CHAN_W-MAX_FRAC:0]      max_int;
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum = SUM_W'(s3_prod_q[0][c]) + SUM_W'(s3_prod_q[1][c]) + SUM_W'(s3_prod_q[2][c])
          + (SUM_W'(1) << (FRAC_SHIFT - 1));
      sum_int = sum[SUM_W-1:FRAC_SHIFT];
      max_rnd = (CHAN_W+1)'(s3_max_q[c]) + (CHAN_W+1)'(1 << (MAX_FRAC - 1));
      max_int = max_rnd[CHAN_W:MAX_FRAC];
      if (s3_zero_q) begin
        s4_pix_d[c] = (|max_int[CHAN_W-MAX_FRAC:PIX_W]) ? '1 : max_int[PIX_W-1:0];
      end else begin
        s4_pix_d[c] = (|sum_int[SUM_W-FRAC_SHIFT-1:PIX_W]) ? '1 : sum_int[PIX_W-1:0];
      end
    end
  end

  pix_rgb_t      s4_pix_q;
  logic [CW-1:0] s4_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_rdy) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy) begin
      s4_pix_q <= s4_pix_d;
      s4_cnt_q <= s3_cnt_q;
    end
  end

  // output register, repeats the color once per vertex
  pix_rgb_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rem_q   <= '0;
    end else if (out_free) begin
      out_valid_q <= s4_valid_q;
      out_rem_q   <= s4_cnt_q;
    end else if (out_take) begin
      out_rem_q   <= out_rem_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_pix_q <= s4_pix_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = out_pix_q[0];
  assign green_o       = out_pix_q[1];
  assign blue_o        = out_pix_q[2];
  assign last_vertex_o = (out_rem_q == CW'(1));

`ifndef ASSERT_OFF
  // a taken non-final vertex is followed by a repeat of the same color
  a_repeat_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !last_vertex_o |=>
      out_valid_q && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("repeat lost or color changed mid item");

  // remaining count stays within the repeat range
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rem_q != '0) && (out_rem_q <= CW'(MAX_REPEAT)))
    else $error("output repeat count out of range");

  // the block stalls requests only with every stage full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && s3_valid_q && s4_valid_q && out_valid_q)
    else $error("request stalled with a free stage");

  // a stage-4 item blocked by the output is still there next cycle
  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && !out_free |=> s4_valid_q && $stable(s4_pix_q))
    else $error("blocked item dropped from last pipeline stage");
`endif

endmodule

/* sim/ambient_cube_vertex_shade_unit_tb.sv */
`timescale 1ns / 100ps

module ambient_cube_vertex_shade_unit_tb;
  import acvs_pkg::*;

  localparam int unsigned MAX_REPEAT   = 16;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned RANDOM_ROUNDS = 4;
  localparam int unsigned ROUND_ITEMS   = 18;

  // index past the end of the register list, writes must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic last;
  } vertex_color_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [NORM_W-1:0] normal_x_i = '0;
  logic signed [NORM_W-1:0] normal_y_i = '0;
  logic signed [NORM_W-1:0] normal_z_i = '0;
  logic [CNT_IN_W-1:0]      vertex_count_i = '0;

  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PIX_W-1:0]         red_o;
  logic [PIX_W-1:0]         green_o;
  logic [PIX_W-1:0]         blue_o;
  logic                     last_vertex_o;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // shadow copy of the light cube and gain
  rgb_t              cube_face [NUM_FACES];
  logic [GAIN_W-1:0] shade_gain;

  vertex_color_t vertex_colors_q [$];

  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned colors_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  logic        rx_idle_en = 1'b0;
  logic        tx_idle_en = 1'b0;

  ambient_cube_vertex_shade_unit #(
    .MAX_REPEAT(MAX_REPEAT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .normal_x_i    (normal_x_i),
    .normal_y_i    (normal_y_i),
    .normal_z_i    (normal_z_i),
    .vertex_count_i(vertex_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_vertex_o (last_vertex_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output backpressure: long hold-off when asked, else random stalls when enabled
  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen   <= hold_requests;
      hold_cycles <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_idle_en) begin
      out_stall_i <= ($urandom_range(99) < 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each accepted color against the oldest expected one
  always @(posedge clk_i) begin : check_colors
    vertex_color_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vertex_colors_q.size() == 0) begin
        $error("unexpected color: r %0d g %0d b %0d last %0d",
               red_o, green_o, blue_o, last_vertex_o);
        error_count++;
      end else begin
        want = vertex_colors_q.pop_front();
        colors_checked++;
        if (red_o !== want.red) begin
          $error("red mismatch: expected %0d, got %0d", want.red, red_o);
          error_count++;
        end
        if (green_o !== want.green) begin
          $error("green mismatch: expected %0d, got %0d", want.green, green_o);
          error_count++;
        end
        if (blue_o !== want.blue) begin
          $error("blue mismatch: expected %0d, got %0d", want.blue, blue_o);
          error_count++;
        end
        if (last_vertex_o !== want.last) begin
          $error("last_vertex mismatch: expected %0d, got %0d", want.last, last_vertex_o);
          error_count++;
        end
      end
    end
  end

  // rounded, clamped ambient color for one normal
  function automatic pix_rgb_t ambient_color(logic signed [NORM_W-1:0] nx,
                                             logic signed [NORM_W-1:0] ny,
                                             logic signed [NORM_W-1:0] nz);
    logic signed [NORM_W-1:0] comp [NUM_AXES];
    longint unsigned          acc [NUM_CHAN];
    longint unsigned          weight;
    longint unsigned          rounded;
    int                       mag;
    int unsigned              peak;
    rgb_t                     face;
    pix_rgb_t                 rgb;
    comp[0] = nx;
    comp[1] = ny;
    comp[2] = nz;
    if (nx == 0 && ny == 0 && nz == 0) begin
      // zero normal: brightest face per channel, unscaled
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        peak = 0;
        for (int f = 0; f < NUM_FACES; f++)
          if (cube_face[f][ch] > peak) peak = cube_face[f][ch];
        rounded = (longint'(peak) + 8) >> MAX_FRAC;
        rgb[ch] = (rounded > 255) ? 8'd255 : rounded[PIX_W-1:0];
      end
    end else begin
      for (int ch = 0; ch < NUM_CHAN; ch++) acc[ch] = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        mag = (comp[a] < 0) ? -int'(comp[a]) : int'(comp[a]);
        face = cube_face[2 * a + ((comp[a] < 0) ? 0 : 1)];
        weight = longint'(mag) * longint'(shade_gain);
        for (int ch = 0; ch < NUM_CHAN; ch++)
          acc[ch] += longint'(face[ch]) * weight;
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        rounded = (acc[ch] + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
        rgb[ch] = (rounded > 255) ? 8'd255 : rounded[PIX_W-1:0];
      end
    end
    return rgb;
  endfunction

  // one register write: setup then access phase, then the bus returns to idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << IDX_LSB;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx <= REG_Z_POS) cube_face[idx] = value[FACE_W-1:0];
    else if (idx == REG_GAIN) shade_gain = value[GAIN_W-1:0];
    reg_writes++;
    @(posedge clk_i);
  endtask

  // offer one request and queue the colors it produces
  task automatic send_vertex(input logic signed [NORM_W-1:0] nx,
                             input logic signed [NORM_W-1:0] ny,
                             input logic signed [NORM_W-1:0] nz,
                             input logic [CNT_IN_W-1:0] cnt);
    int unsigned   reps;
    pix_rgb_t      rgb;
    vertex_color_t item;
    if (tx_idle_en && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i     <= 1'b1;
    normal_x_i     <= nx;
    normal_y_i     <= ny;
    normal_z_i     <= nz;
    vertex_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
    rgb  = ambient_color(nx, ny, nz);
    reps = (cnt > MAX_REPEAT) ? MAX_REPEAT : cnt;
    for (int unsigned k = 0; k < reps; k++) begin
      item.red   = rgb[0];
      item.green = rgb[1];
      item.blue  = rgb[2];
      item.last  = (k + 1 == reps);
      vertex_colors_q.push_back(item);
    end
    requests_sent++;
  endtask

  // stop offering, wait for all colors, then let the pipeline empty
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (vertex_colors_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [FACE_W-1:0] rand_face();
    case ($urandom_range(5))
      0: return '1;
      1: return '0;
      2: return {4'h0, 8'($urandom), 12'($urandom_range(255)), 12'($urandom_range(255))} >> 0;
      default: return {4'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return GAIN_RESET;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [NORM_W-1:0] rand_component();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 18) begin
      case ($urandom_range(4))
        0: return 16'sd16384;
        1: return -16'sd16384;
        2: return 16'h8000;
        3: return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    if (pick < 35) return 16'($urandom);
    return 16'($urandom_range(32768)) - 16'd16384;
  endfunction

  function automatic logic [CNT_IN_W-1:0] rand_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 65) return 5'($urandom_range(3, 1));
    if (pick < 90) return 5'($urandom_range(16, 4));
    return 5'($urandom_range(31, 17));
  endfunction

  // reset defaults: zero faces give black with the reset gain
  task automatic test_reset_values();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    send_vertex(16384, -300, 0, 2);
    send_vertex(0, 0, 0, 1);
    drain_pipeline();
  endtask

  // each face alone, zero normal, out-of-range component, count edges
  task automatic test_face_select();
    write_reg(REG_X_NEG, 36'h010_020_FF0);
    write_reg(REG_X_POS, 36'h0F0_800_123);
    write_reg(REG_Y_NEG, 36'hFFF_000_001);
    write_reg(REG_Y_POS, 36'h400_400_400);
    write_reg(REG_Z_NEG, 36'h008_7FF_800);
    write_reg(REG_Z_POS, 36'h555_AAA_0FF);
    send_vertex(16384, 0, 0, 1);
    send_vertex(-16384, 0, 0, 2);
    send_vertex(0, 16384, 0, 1);
    send_vertex(0, -16384, 0, 1);
    send_vertex(0, 0, 16384, 3);
    send_vertex(0, 0, -16384, 1);
    send_vertex(0, 0, 0, 2);
    send_vertex(-32768, 0, 0, 1);
    send_vertex(8192, -8192, 4096, 0);
    send_vertex(11585, -11585, 1, 16);
    send_vertex(-1, -1, -1, 17);
    send_vertex(32767, 0, -5000, 31);
    drain_pipeline();
  endtask

  // brightest faces with maximum gain must clamp
  task automatic test_saturation();
    for (int f = 0; f < NUM_FACES; f++) write_reg(REG_X_NEG + IDX_W'(f), '1);
    write_reg(REG_GAIN, '1);
    send_vertex(16384, 16384, 16384, 1);
    send_vertex(1, 1, 1, 2);
    send_vertex(0, 0, 0, 1);
    send_vertex(-32768, -32768, -32768, 1);
    drain_pipeline();
  endtask

  // zero gain kills the weighted path but not the zero-normal path
  task automatic test_zero_gain();
    write_reg(REG_X_POS, 36'h123_456_789);
    write_reg(REG_GAIN, '0);
    write_reg(REG_UNUSED, '1);
    send_vertex(16384, -16384, 100, 1);
    send_vertex(0, 0, 0, 2);
    drain_pipeline();
  endtask

  // random cubes and random requests, first round without any idling
  task automatic test_random_vertices();
    logic signed [NORM_W-1:0] nx, ny, nz;
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      for (int f = 0; f < NUM_FACES; f++) write_reg(REG_X_NEG + IDX_W'(f), rand_face());
      write_reg(REG_GAIN, rand_gain());
      tx_idle_en = (r != 0);
      rx_idle_en <= (r != 0);
      for (int i = 0; i < ROUND_ITEMS; i++) begin
        if ($urandom_range(99) < 5) begin
          nx = '0;
          ny = '0;
          nz = '0;
        end else begin
          nx = rand_component();
          ny = rand_component();
          nz = rand_component();
        end
        send_vertex(nx, ny, nz, rand_count());
      end
      drain_pipeline();
    end
  endtask

  // hold the output long enough for the request side to back up
  task automatic test_output_holdoff();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b1;
    hold_requests++;
    for (int i = 0; i < 20; i++)
      send_vertex(rand_component(), rand_component(), rand_component(),
                  5'($urandom_range(2, 1)));
    drain_pipeline();
  endtask

  initial begin
    for (int f = 0; f < NUM_FACES; f++) cube_face[f] = '0;
    shade_gain = GAIN_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_face_select();
    test_saturation();
    test_zero_gain();
    test_random_vertices();
    test_output_holdoff();

    $display("covered %0d requests and %0d vertex colors over %0d register writes,",
             requests_sent, colors_checked, reg_writes);
    $display("face corners, clamping, zero normals, count limits and an output hold-off");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* ambient_cube_vertex_shade_unit.f */
sv/acvs_pkg.sv
sv/ambient_cube_vertex_shade_unit.sv
sim/ambient_cube_vertex_shade_unit_tb.sv
